// File: rtl/tcsw_pkg.sv
// ----------------------------------------------------------------------------
// tcsw_pkg
// shared types and codes of the scrollback writer: command codes, character
// codes, register indexes and the controller/datapath command and status bundles
// ----------------------------------------------------------------------------
package tcsw_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] CMD_PUT    = 2'd0;
   localparam logic [1:0] CMD_SCROLL = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   // configuration register indexes
   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_VISIBLE_ROWS = 1'b1;

   localparam logic [7:0] COLUMN_COUNT_RESET = 8'd128;
   localparam logic [7:0] VISIBLE_ROWS_RESET = 8'd48;

   // memory write source
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_SWEEP = 2'd1;
   localparam logic [1:0] MEM_CHAR  = 2'd2;
   localparam logic [1:0] MEM_LCLR  = 2'd3;

   // cursor column update
   localparam logic [1:0] COL_HOLD = 2'd0;
   localparam logic [1:0] COL_ZERO = 2'd1;
   localparam logic [1:0] COL_INC  = 2'd2;

   // position accumulator update
   localparam logic [2:0] ACC_HOLD   = 3'd0;
   localparam logic [2:0] ACC_SCROLL = 3'd1;
   localparam logic [2:0] ACC_BASE   = 3'd2;
   localparam logic [2:0] ACC_ADD    = 3'd3;
   localparam logic [2:0] ACC_SUB    = 3'd4;

   // view top update
   localparam logic [1:0] TOP_HOLD = 2'd0;
   localparam logic [1:0] TOP_ZERO = 2'd1;
   localparam logic [1:0] TOP_ACC  = 2'd2;
   localparam logic [1:0] TOP_FIX  = 2'd3;

   typedef struct packed {
      logic       load_req;
      logic [1:0] mem_op;
      logic [1:0] col_op;
      logic       line_adv;
      logic       cnt_clr;
      logic       cnt_inc;
      logic [2:0] acc_op;
      logic [1:0] top_op;
      logic       cell_cap;
      logic       rsp_load;
   } tcsw_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       is_cr;
      logic       is_lf;
      logic       col_wrap;
      logic       sweep_last;
      logic       line_last;
      logic       acc_neg;
      logic       acc_ge;
      logic       full;
      logic       rsp_free;
   } tcsw_sts_type;

endpackage

// File: rtl/tcsw_ram.sv
// ----------------------------------------------------------------------------
// tcsw_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tcsw_ctrl.sv
// ----------------------------------------------------------------------------
// tcsw_ctrl
// sequencer of the scrollback writer: reset sweep, command dispatch, line
// clearing, ring modulo steps and result hand-off
// ----------------------------------------------------------------------------
module tcsw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tcsw_pkg::tcsw_sts_type sts,
   output tcsw_pkg::tcsw_cmd_type cmd
);

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_EXEC = 4'd2;
   localparam logic [3:0] ST_RDW  = 4'd3;
   localparam logic [3:0] ST_NL   = 4'd4;
   localparam logic [3:0] ST_LCLR = 4'd5;
   localparam logic [3:0] ST_NLM  = 4'd6;
   localparam logic [3:0] ST_SCRM = 4'd7;
   localparam logic [3:0] ST_SCRB = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mem_op   = tcsw_pkg::MEM_NONE;
      cmd.col_op   = tcsw_pkg::COL_HOLD;
      cmd.acc_op   = tcsw_pkg::ACC_HOLD;
      cmd.top_op   = tcsw_pkg::TOP_HOLD;
      case (state_ff)
         ST_CLR: begin
            cmd.mem_op  = tcsw_pkg::MEM_SWEEP;
            cmd.cnt_inc = 1'b1;
            if (sts.sweep_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.cmd)
               tcsw_pkg::CMD_PUT: begin
                  if (sts.is_cr) begin
                     cmd.col_op = tcsw_pkg::COL_ZERO;
                     state_in   = ST_DONE;
                  end else if (sts.is_lf) begin
                     state_in = ST_NL;
                  end else begin
                     cmd.mem_op = tcsw_pkg::MEM_CHAR;
                     cmd.col_op = tcsw_pkg::COL_INC;
                     state_in   = sts.col_wrap ? ST_NL : ST_DONE;
                  end
               end
               tcsw_pkg::CMD_SCROLL: begin
                  cmd.acc_op = tcsw_pkg::ACC_SCROLL;
                  state_in   = ST_SCRM;
               end
               tcsw_pkg::CMD_READ: begin
                  state_in = ST_RDW;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RDW: begin
            cmd.cell_cap = 1'b1;
            state_in     = ST_DONE;
         end
         ST_NL: begin
            cmd.col_op   = tcsw_pkg::COL_ZERO;
            cmd.line_adv = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_in     = ST_LCLR;
         end
         ST_LCLR: begin
            cmd.mem_op  = tcsw_pkg::MEM_LCLR;
            cmd.cnt_inc = 1'b1;
            if (sts.line_last) begin
               cmd.cnt_clr = 1'b1;
               cmd.acc_op  = tcsw_pkg::ACC_BASE;
               state_in    = ST_NLM;
            end
         end
         ST_NLM: begin
            if (sts.acc_neg && !sts.full) begin
               cmd.top_op = tcsw_pkg::TOP_ZERO;
               state_in   = ST_DONE;
            end else if (sts.acc_neg) begin
               cmd.acc_op = tcsw_pkg::ACC_ADD;
            end else if (sts.acc_ge) begin
               cmd.acc_op = tcsw_pkg::ACC_SUB;
            end else begin
               cmd.top_op = tcsw_pkg::TOP_ACC;
               state_in   = ST_DONE;
            end
         end
         ST_SCRM: begin
            if (sts.acc_neg && !sts.full) begin
               cmd.top_op = tcsw_pkg::TOP_ZERO;
               cmd.acc_op = tcsw_pkg::ACC_BASE;
               state_in   = ST_SCRB;
            end else if (sts.acc_neg) begin
               cmd.acc_op = tcsw_pkg::ACC_ADD;
            end else if (sts.acc_ge) begin
               cmd.acc_op = tcsw_pkg::ACC_SUB;
            end else begin
               cmd.top_op = tcsw_pkg::TOP_ACC;
               cmd.acc_op = tcsw_pkg::ACC_BASE;
               state_in   = ST_SCRB;
            end
         end
         ST_SCRB: begin
            if (sts.acc_neg) begin
               cmd.acc_op = tcsw_pkg::ACC_ADD;
            end else if (sts.acc_ge) begin
               cmd.acc_op = tcsw_pkg::ACC_SUB;
            end else begin
               cmd.top_op = tcsw_pkg::TOP_FIX;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

endmodule

// File: rtl/tcsw_dpath.sv
// ----------------------------------------------------------------------------
// tcsw_dpath
// datapath of the scrollback writer: cursor, view and full registers,
// configuration registers, position accumulator, memory address mux and the
// result register
// ----------------------------------------------------------------------------
module tcsw_dpath #(
   parameter int RING_LINES  = 256,
   parameter int MAX_COLUMNS = 128
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [31:0]                                req_tdata,
   input  logic [1:0]                                 req_tuser,
   output logic [31:0]                                rsp_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic                                       csr_valid,
   input  logic                                       csr_index,
   input  logic [7:0]                                 csr_data,
   input  tcsw_pkg::tcsw_cmd_type                     cmd,
   output tcsw_pkg::tcsw_sts_type                     sts,
   output logic                                       mem_wr_en,
   output logic [$clog2(RING_LINES*MAX_COLUMNS)-1:0] mem_wr_addr,
   output logic [7:0]                                 mem_wr_data,
   output logic [$clog2(RING_LINES*MAX_COLUMNS)-1:0] mem_rd_addr,
   input  logic [7:0]                                 mem_rd_data
);

   localparam int DEPTH = RING_LINES * MAX_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(RING_LINES);
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int SW    = ((LW > 8) ? LW : 8) + 2;

   localparam logic signed [SW-1:0] RING_S    = SW'(RING_LINES);
   localparam logic [LW-1:0]        LINE_LAST = LW'(RING_LINES - 1);

   logic [CW-1:0]        col_ff, col_in;
   logic [LW-1:0]        line_ff, line_in;
   logic [LW-1:0]        top_ff, top_in;
   logic                 full_ff, full_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [7:0]           cols_ff, cols_in;
   logic [7:0]           rows_ff, rows_in;
   logic [1:0]           cmd_ff;
   logic [7:0]           char_ff;
   logic [8:0]           amt_ff;
   logic [LW-1:0]        rline_ff;
   logic [CW-1:0]        rcol_ff;
   logic                 rdok_ff;
   logic [7:0]           cell_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff;

   logic [CW:0]          eff_cols;
   logic [CW+8:0]        cols_wide;
   logic [LW+7:0]        rline_wide;
   logic [CW+6:0]        rcol_wide;
   logic [LW+7:0]        line_out_wide;
   logic [LW+7:0]        top_out_wide;
   logic [CW+6:0]        col_out_wide;
   logic signed [SW-1:0] line_s, top_s, rows_s, amt_s;
   logic [LW-1:0]        acc_low, acc_next;
   logic [7:0]           cell_out;

   function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] ln,
                                                input logic [CW-1:0] cl);
      return AW'(ln) * AW'(MAX_COLUMNS) + AW'(cl);
   endfunction

   // effective column count: zero acts as one, clamp to the line stride
   assign cols_wide = {{(CW+1){1'b0}}, cols_ff};
   always_comb begin
      if (cols_ff == 8'd0) begin
         eff_cols = (CW+1)'(1);
      end else if (32'(cols_ff) > MAX_COLUMNS) begin
         eff_cols = (CW+1)'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_wide[CW:0];
      end
   end

   assign rline_wide = {{LW{1'b0}}, req_tdata[24:17]};
   assign rcol_wide  = {{CW{1'b0}}, req_tdata[31:25]};

   assign line_s = $signed({{(SW-LW){1'b0}}, line_ff});
   assign top_s  = $signed({{(SW-LW){1'b0}}, top_ff});
   assign rows_s = $signed({{(SW-8){1'b0}}, rows_ff});
   assign amt_s  = $signed({{(SW-9){amt_ff[8]}}, amt_ff});

   assign acc_low  = acc_ff[LW-1:0];
   assign acc_next = (acc_low == LINE_LAST) ? '0 : acc_low + LW'(1);

   // request payload capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_tuser;
         char_ff  <= req_tdata[7:0];
         amt_ff   <= req_tdata[16:8];
         rline_ff <= rline_wide[LW-1:0];
         rcol_ff  <= rcol_wide[CW-1:0];
         rdok_ff  <= (32'(req_tdata[24:17]) < RING_LINES) &&
                     (32'(req_tdata[31:25]) < MAX_COLUMNS);
      end
      if (cmd.cell_cap) begin
         cell_ff <= rdok_ff ? mem_rd_data : 8'd0;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      case (cmd.acc_op)
         tcsw_pkg::ACC_SCROLL: acc_in = top_s + amt_s;
         tcsw_pkg::ACC_BASE:   acc_in = line_s - rows_s;
         tcsw_pkg::ACC_ADD:    acc_in = acc_ff + RING_S;
         tcsw_pkg::ACC_SUB:    acc_in = acc_ff - RING_S;
         default:              acc_in = acc_ff;
      endcase
   end

   always_comb begin
      col_in = col_ff;
      case (cmd.col_op)
         tcsw_pkg::COL_ZERO: col_in = '0;
         tcsw_pkg::COL_INC:  col_in = col_ff + CW'(1);
         default:            col_in = col_ff;
      endcase
      line_in = line_ff;
      full_in = full_ff;
      if (cmd.line_adv) begin
         if (line_ff == LINE_LAST) begin
            line_in = '0;
            full_in = 1'b1;
         end else begin
            line_in = line_ff + LW'(1);
         end
      end
      top_in = top_ff;
      case (cmd.top_op)
         tcsw_pkg::TOP_ZERO: top_in = '0;
         tcsw_pkg::TOP_ACC:  top_in = acc_low;
         tcsw_pkg::TOP_FIX:  top_in = (top_ff == acc_next) ? acc_low : top_ff;
         default:            top_in = top_ff;
      endcase
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + AW'(1);
      end
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_valid) begin
         case (csr_index)
            tcsw_pkg::CSR_COLUMN_COUNT: cols_in = csr_data;
            tcsw_pkg::CSR_VISIBLE_ROWS: rows_in = csr_data;
            default:                    cols_in = cols_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         full_ff      <= 1'b0;
         cnt_ff       <= '0;
         cols_ff      <= tcsw_pkg::COLUMN_COUNT_RESET;
         rows_ff      <= tcsw_pkg::VISIBLE_ROWS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         full_ff      <= full_in;
         cnt_ff       <= cnt_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // memory ports
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cell_addr(line_ff, col_ff);
      mem_wr_data = char_ff;
      case (cmd.mem_op)
         tcsw_pkg::MEM_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = 8'd0;
         end
         tcsw_pkg::MEM_CHAR: begin
            mem_wr_en = 1'b1;
         end
         tcsw_pkg::MEM_LCLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cell_addr(line_ff, cnt_ff[CW-1:0]);
            mem_wr_data = 8'd0;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   assign mem_rd_addr = cell_addr(rline_ff, rcol_ff);

   // result register
   assign line_out_wide = {8'd0, line_ff};
   assign top_out_wide  = {8'd0, top_ff};
   assign col_out_wide  = {7'd0, col_ff};
   assign cell_out      = (cmd_ff == tcsw_pkg::CMD_READ) ? cell_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= {full_ff, top_out_wide[7:0], line_out_wide[7:0],
                         col_out_wide[6:0], cell_out};
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // status to the controller
   assign sts.cmd        = cmd_ff;
   assign sts.is_cr      = (char_ff == tcsw_pkg::CHAR_CR);
   assign sts.is_lf      = (char_ff == tcsw_pkg::CHAR_LF);
   assign sts.col_wrap   = (({1'b0, col_ff} + (CW+1)'(1)) >= eff_cols);
   assign sts.sweep_last = (cnt_ff == AW'(DEPTH - 1));
   assign sts.line_last  = (({1'b0, cnt_ff[CW-1:0]} + (CW+1)'(1)) == eff_cols);
   assign sts.acc_neg    = acc_ff[SW-1];
   assign sts.acc_ge     = (acc_ff >= RING_S);
   assign sts.full       = full_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

// File: rtl/text_console_scrollback_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_scrollback_writer_unit
// text console character store kept as a ring of scrollback lines
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole character memory,
// one cell a cycle, RING_LINES*MAX_COLUMNS cells (32768 at the defaults);
// req_tready stays low until it ends, configuration writes are taken as ever.
// Each request then takes a fixed path through the sequencer, one request at
// a time: a printable byte or a carriage return goes from dispatch straight
// to the result hand-off, a read passes one more state for the registered
// memory read. A line feed or a column wrap adds a line-advance state, a
// clearing pass over the cells of the new line (the effective column count)
// and the modulo steps. A scroll adds the modulo steps for the new view top
// and then for the view base. The modulo steps come from one shared
// add/subtract unit that moves a view position by RING_LINES a cycle; with
// RING_LINES of 256 or more it needs at most one step per reduction. A new
// request is taken while a finished result still waits in the output register.
module text_console_scrollback_writer_unit #(
   parameter int RING_LINES  = 256,
   parameter int MAX_COLUMNS = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_code, [16:8] scroll_amount, [24:17] read_line, [31:25] read_column
   input  logic [31:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] cell_data, [14:8] cursor_column, [22:15] cursor_line,
   // [30:23] view_top, [31] ring_full
   output logic [31:0] rsp_tdata,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int AW = $clog2(RING_LINES * MAX_COLUMNS);

   tcsw_pkg::tcsw_cmd_type cmd;
   tcsw_pkg::tcsw_sts_type sts;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   // registers accept a transfer every cycle
   assign csr_ready = 1'b1;

   // sequencer: sweep, dispatch, line clear, modulo steps, result hand-off
   tcsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // cursor, view, configuration and result registers
   tcsw_dpath #(
      .RING_LINES  (RING_LINES),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // character store, line stride MAX_COLUMNS
   tcsw_ram #(
      .WIDTH (8),
      .DEPTH (RING_LINES * MAX_COLUMNS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: verif/tcsw_tb_pkg.sv
// ----------------------------------------------------------------------------
// tcsw_tb_pkg
// scoreboard of the scrollback writer bench: keeps its own copy of the
// character ring, cursor, view top and registers, works out the status that
// each request transfer must return and checks the returned transfers in order
// ----------------------------------------------------------------------------
package tcsw_tb_pkg;

   import tcsw_pkg::*;

   localparam int RING_LINES  = 256;
   localparam int MAX_COLUMNS = 128;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [6:0]        read_column;
      logic [7:0]        read_line;
      logic signed [8:0] scroll_amount;
      logic [7:0]        char_code;
   } console_request_type;

   // status payload, last field in the lowest bits
   typedef struct packed {
      logic       ring_full;
      logic [7:0] view_top;
      logic [7:0] cursor_line;
      logic [6:0] cursor_column;
      logic [7:0] cell_data;
   } console_status_type;

   class console_scoreboard;

      logic [7:0]         cells [RING_LINES*MAX_COLUMNS];
      int                 col_pos;
      int                 line_pos;
      int                 top_pos;
      bit                 full;
      int                 column_count;
      int                 visible_rows;
      console_status_type expected_status [$];
      int                 errors;

      function new();
         foreach (cells[i]) cells[i] = 8'h00;
         col_pos      = 0;
         line_pos     = 0;
         top_pos      = 0;
         full         = 1'b0;
         column_count = COLUMN_COUNT_RESET;
         visible_rows = VISIBLE_ROWS_RESET;
         errors       = 0;
      endfunction

      function void set_register(logic index, logic [7:0] value);
         if (index == CSR_COLUMN_COUNT) begin
            column_count = value;
         end else begin
            visible_rows = value;
         end
      endfunction

      function int used_columns();
         if (column_count == 0) return 1;
         if (column_count > MAX_COLUMNS) return MAX_COLUMNS;
         return column_count;
      endfunction

      function int ring_wrap(int v);
         int m;
         m = v % RING_LINES;
         if (m < 0) m += RING_LINES;
         return m;
      endfunction

      function void advance_line();
         int y;
         col_pos = 0;
         line_pos++;
         if (line_pos >= RING_LINES) begin
            full     = 1'b1;
            line_pos = 0;
         end
         // only the first column-count cells of the new line are cleared
         for (int i = 0; i < used_columns(); i++) cells[line_pos*MAX_COLUMNS + i] = 8'h00;
         y = line_pos - visible_rows;
         if (y < 0) y = full ? ring_wrap(y) : 0;
         top_pos = y;
      endfunction

      function void put_byte(logic [7:0] c);
         if (c == CHAR_CR) begin
            col_pos = 0;
         end else if (c == CHAR_LF) begin
            advance_line();
         end else begin
            if (col_pos < MAX_COLUMNS) cells[line_pos*MAX_COLUMNS + col_pos] = c;
            col_pos++;
            if (col_pos >= used_columns()) advance_line();
         end
      endfunction

      function void scroll_view(logic signed [8:0] amount);
         int y;
         int base;
         y    = top_pos + int'(amount);
         base = line_pos - visible_rows;
         if (y < 0) begin
            y = full ? ring_wrap(y) : 0;
         end else if (y >= RING_LINES) begin
            y = ring_wrap(y);
         end
         // the view may not stop one row past the cursor
         if (y == ring_wrap(base + 1)) y = ring_wrap(base);
         top_pos = y;
      endfunction

      function void note_request(logic [1:0] cmd, console_request_type req);
         console_status_type st;
         logic [7:0]         data;
         data = 8'h00;
         case (cmd)
            CMD_PUT:    put_byte(req.char_code);
            CMD_SCROLL: scroll_view(req.scroll_amount);
            CMD_READ:   data = cells[int'(req.read_line)*MAX_COLUMNS + int'(req.read_column)];
            default:    ;
         endcase
         st.cell_data     = data;
         st.cursor_column = col_pos[6:0];
         st.cursor_line   = line_pos[7:0];
         st.view_top      = top_pos[7:0];
         st.ring_full     = full;
         expected_status.push_back(st);
      endfunction

      function void check_result(console_status_type got);
         console_status_type want;
         if (expected_status.size() == 0) begin
            $error("status transfer with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.cell_data !== want.cell_data) begin
            $error("cell_data: expected %0d, got %0d", want.cell_data, got.cell_data);
            errors++;
         end
         if (got.cursor_column !== want.cursor_column) begin
            $error("cursor_column: expected %0d, got %0d",
                   want.cursor_column, got.cursor_column);
            errors++;
         end
         if (got.cursor_line !== want.cursor_line) begin
            $error("cursor_line: expected %0d, got %0d", want.cursor_line, got.cursor_line);
            errors++;
         end
         if (got.view_top !== want.view_top) begin
            $error("view_top: expected %0d, got %0d", want.view_top, got.view_top);
            errors++;
         end
         if (got.ring_full !== want.ring_full) begin
            $error("ring_full: expected %0d, got %0d", want.ring_full, got.ring_full);
            errors++;
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

   endclass

endpackage

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// bench of the scrollback writer: a directed opening over the field extremes,
// every command and the corner cases of wrapping, clamping and clearing, then
// random phases of console text, scrolls and cell reads under several register
// settings and idle patterns, each status transfer checked against the
// scoreboard's own copy of the console
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import tcsw_pkg::*;
   import tcsw_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   console_scoreboard sb;

   // idle odds out of a hundred, set per phase
   int send_idle;
   int recv_stall;
   // long receiver hold-off, started by the stimulus and counted below
   bit hold_request;
   int hold_left;
   int cycle_count;

   text_console_scrollback_writer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // status receiver: checks each transfer, then picks the next ready value
   initial begin
      rsp_tready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(console_status_type'(rsp_tdata));
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   function automatic console_request_type make_request(logic [7:0] c, int amount,
                                                        logic [7:0] line, logic [6:0] col);
      console_request_type r;
      r.char_code     = c;
      r.scroll_amount = 9'(amount);
      r.read_line     = line;
      r.read_column   = col;
      return r;
   endfunction

   // scroll amount that lands the view one row past the cursor
   function automatic int past_cursor_amount();
      return sb.ring_wrap(sb.line_pos - sb.visible_rows + 1) - sb.top_pos;
   endfunction

   // one request transfer, with a random lead-in gap; valid stays high after it
   task automatic send_item(input logic [1:0] cmd, input console_request_type req);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= req;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, req);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // both registers, back to back, only once every status has come back
   task automatic write_config(input logic [7:0] cols, input logic [7:0] rows);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_COLUMN_COUNT;
      csr_data  <= cols;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_COLUMN_COUNT, cols);
      csr_index <= CSR_VISIBLE_ROWS;
      csr_data  <= rows;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_VISIBLE_ROWS, rows);
      csr_valid <= 1'b0;
   endtask

   // mostly console text with random content, some scrolls near the
   // interesting positions, reads around the cursor and a little noise
   task automatic make_item(input int put_pct, output logic [1:0] cmd,
                            output console_request_type req);
      int roll;
      int rest;
      int span;
      int pick;
      int cols;
      req  = console_request_type'($urandom);
      roll = $urandom_range(99);
      span = 100 - put_pct;
      rest = roll - put_pct;
      pick = $urandom_range(99);
      if (roll < put_pct) begin
         cmd = CMD_PUT;
         if (pick < 8) begin
            req.char_code = CHAR_LF;
         end else if (pick < 13) begin
            req.char_code = CHAR_CR;
         end else if (pick >= 25) begin
            req.char_code = 8'($urandom_range(126, 32));
         end
      end else if (rest * 100 < span * 45) begin
         cmd = CMD_SCROLL;
         if (pick < 15) begin
            req.scroll_amount = 9'(past_cursor_amount());
         end else if (pick < 60) begin
            req.scroll_amount = 9'(int'($urandom_range(8)) - 4);
         end else begin
            req.scroll_amount = 9'(int'($urandom_range(510)) - 255);
         end
      end else if (rest * 100 < span * 93) begin
         cmd  = CMD_READ;
         cols = sb.used_columns();
         if (pick < 60) begin
            req.read_line = 8'(sb.ring_wrap(sb.line_pos - int'($urandom_range(1))));
         end
         if ($urandom_range(99) < 70) begin
            req.read_column = 7'($urandom_range((cols + 4 > 127) ? 127 : cols + 4));
         end
      end else begin
         cmd = CMD_UNUSED;
      end
   endtask

   task automatic run_items(input int count, input int put_pct);
      logic [1:0]          cmd;
      console_request_type req;
      repeat (count) begin
         make_item(put_pct, cmd, req);
         send_item(cmd, req);
      end
   endtask

   task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
                            input int idle, input int stall,
                            input int count, input int put_pct);
      write_config(cols, rows);
      send_idle  = idle;
      recv_stall = stall;
      run_items(count, put_pct);
   endtask

   initial begin
      sb           = new();
      send_idle    = 0;
      recv_stall   = 0;
      hold_request = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_PUT;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_COLUMN_COUNT;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values written back, field extremes, every command
      write_config(COLUMN_COUNT_RESET, VISIBLE_ROWS_RESET);
      send_item(CMD_READ,   make_request(8'h00, 0, 8'd0, 7'd0));
      send_item(CMD_READ,   make_request(8'h00, 0, 8'd255, 7'd127));
      send_item(CMD_PUT,    make_request(8'h41, 0, 8'd0, 7'd0));
      send_item(CMD_PUT,    make_request(8'h00, 0, 8'd0, 7'd0));
      send_item(CMD_PUT,    make_request(8'hff, 0, 8'd0, 7'd0));
      send_item(CMD_PUT,    make_request(CHAR_CR, 0, 8'd0, 7'd0));
      send_item(CMD_PUT,    make_request(CHAR_LF, 0, 8'd0, 7'd0));
      send_item(CMD_READ,   make_request(8'h00, 0, 8'd0, 7'd2));
      // negative view top clamps while the ring is not yet full
      send_item(CMD_SCROLL, make_request(8'h00, -255, 8'd0, 7'd0));
      send_item(CMD_SCROLL, make_request(8'h00, 255, 8'd0, 7'd0));
      send_item(CMD_SCROLL, make_request(8'h00, -1, 8'd0, 7'd0));
      send_item(CMD_SCROLL, make_request(8'h00, 0, 8'd0, 7'd0));
      send_item(CMD_UNUSED, make_request(8'h5a, 77, 8'd3, 7'd9));
      // scroll that would stop one row past the cursor
      send_item(CMD_SCROLL, make_request(8'h00, past_cursor_amount(), 8'd0, 7'd0));
      // column count lowered under the cursor: byte stored, then line feed
      for (int i = 0; i < 5; i++) begin
         send_item(CMD_PUT, make_request(8'(8'h61 + i), 0, 8'd0, 7'd0));
      end
      write_config(8'd3, VISIBLE_ROWS_RESET);
      send_item(CMD_PUT,    make_request(8'h7a, 0, 8'd0, 7'd0));
      send_item(CMD_READ,   make_request(8'h00, 0, 8'd1, 7'd5));
      // out-of-range column counts: zero acts as one, large as the maximum
      write_config(8'd0, 8'd1);
      send_item(CMD_PUT,    make_request(8'h71, 0, 8'd0, 7'd0));
      send_item(CMD_PUT,    make_request(8'h72, 0, 8'd0, 7'd0));
      write_config(8'd200, 8'd255);
      send_item(CMD_PUT,    make_request(8'h6b, 0, 8'd0, 7'd0));
      send_item(CMD_READ,   make_request(8'h00, 0, 8'd4, 7'd0));

      // random phases; the narrow ones push the cursor around the ring
      run_phase(8'd128, 8'd48, 0, 0, 40, 70);
      run_phase(8'd1, 8'd1, 75, 0, 200, 92);
      run_phase(8'd2, 8'd255, 0, 75, 60, 80);

      // long receiver hold-off while the sender keeps offering
      write_config(8'd7, 8'd3);
      send_idle    = 0;
      recv_stall   = 0;
      hold_request = 1'b1;
      run_items(40, 70);
      // sender pauses until every status is back
      req_tvalid <= 1'b0;
      wait_drained();
      run_items(20, 70);

      run_phase(8'd0, 8'd200, 18, 18, 100, 90);
      run_phase(8'd5, 8'd16, 0, 75, 50, 60);
      run_phase(8'd128, 8'd1, 75, 0, 40, 60);
      req_tvalid <= 1'b0;

      // drain, then a short quiet stretch to catch stray transfers
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/tcsw_pkg.sv
rtl/tcsw_ram.sv
rtl/tcsw_ctrl.sv
rtl/tcsw_dpath.sv
rtl/text_console_scrollback_writer_unit.sv
verif/tcsw_tb_pkg.sv
verif/tb_top.sv
